FILE: rtl/core/swde_pkg.sv
`default_nettype none
package swde_pkg;

   localparam int SampleWidth       = 16;
   localparam int WidthGainWidth    = 11;
   localparam int SurroundGainWidth = 9;
   localparam int DelayWidth        = 12;
   localparam int CsrIndexWidth     = 2;
   localparam int CsrDataWidth      = 12;
   localparam int DefaultDelayDepth = 4096;

   localparam logic [WidthGainWidth-1:0]    WidthGainReset    = 11'd256;
   localparam logic [SurroundGainWidth-1:0] SurroundGainReset = 9'd0;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_WIDTH_GAIN    = 2'd0,
      CSR_SURROUND_GAIN = 2'd1,
      CSR_DELAY_LEN     = 2'd2
   } csr_index_type;

endpackage
`default_nettype wire

FILE: rtl/core/swde_req_if.sv
`default_nettype none
interface swde_req_if;
   import swde_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [SampleWidth-1:0] left_in;
   logic signed [SampleWidth-1:0] right_in;

   modport source (output valid, output left_in, output right_in, input ready);
   modport sink   (input valid, input left_in, input right_in, output ready);

endinterface
`default_nettype wire

FILE: rtl/core/swde_rsp_if.sv
`default_nettype none
interface swde_rsp_if;
   import swde_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [SampleWidth-1:0] left_out;
   logic signed [SampleWidth-1:0] right_out;

   modport source (output valid, output left_out, output right_out, input ready);
   modport sink   (input valid, input left_out, input right_out, output ready);

endinterface
`default_nettype wire

FILE: rtl/core/stereo_width_delay_enhancer.sv
`default_nettype none
// a request accepted is registered in stage 1, then moves through stages 2 to 4
// and reaches rsp.valid from the stage 5 output register
// throughput: one request per cycle unless rsp.ready stalls, through a five-stage
// pipeline and a dual-port ring memory (write and read in the same stage)
// reset: the ring is swept to zero over all DelayDepth entries, req.ready low meanwhile
// a delay write is reduced modulo the depth at its own edge, no stall
module stereo_width_delay_enhancer #(
   parameter int DelayDepth = swde_pkg::DefaultDelayDepth
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   swde_req_if.sink                                   req,
   swde_rsp_if.source                                 rsp,
   input  wire logic                                  csr_we,
   input  wire logic [swde_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire logic [swde_pkg::CsrDataWidth-1:0]     csr_wdata
);
   import swde_pkg::*;

   localparam int AW = $clog2(DelayDepth);
   localparam logic [AW-1:0] LastAddr = AW'(DelayDepth - 1);
   localparam logic [AW:0]   DepthX   = (AW + 1)'(DelayDepth);

   function automatic logic signed [SampleWidth-1:0] sat16(input logic signed [23:0] x);
      logic signed [SampleWidth-1:0] y;
      if (x > 24'sd32767) begin
         y = 16'sh7fff;
      end else if (x < -24'sd32768) begin
         y = -16'sh8000;
      end else begin
         y = x[SampleWidth-1:0];
      end
      return y;
   endfunction

   // configuration
   logic [WidthGainWidth-1:0]    width_gain_ff;
   logic [SurroundGainWidth-1:0] surround_gain_ff;
   logic                         delay_start;
   logic [AW-1:0]                back;
   logic                         surround_on;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_gain_ff    <= WidthGainReset;
         surround_gain_ff <= SurroundGainReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WIDTH_GAIN: begin
               width_gain_ff <= csr_wdata[WidthGainWidth-1:0];
            end
            CSR_SURROUND_GAIN: begin
               surround_gain_ff <= csr_wdata[SurroundGainWidth-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign delay_start = csr_we && (csr_index == CSR_DELAY_LEN);
   assign surround_on = (surround_gain_ff != '0);

   swde_delay_mod #(.DelayDepth(DelayDepth)) u_delay_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (delay_start),
      .value     (csr_wdata[DelayWidth-1:0]),
      .remainder (back)
   );

   // pipeline control
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic adv1, adv2, adv3, adv4, adv5;
   logic take1, take2, take3, take4, take5;
   logic ring_clearing;
   logic accept;

   assign adv5  = v5_ff && rsp.ready;
   assign take5 = !v5_ff || adv5;
   assign adv4  = v4_ff && take5;
   assign take4 = !v4_ff || adv4;
   assign adv3  = v3_ff && take4;
   assign take3 = !v3_ff || adv3;
   assign adv2  = v2_ff && take3;
   assign take2 = !v2_ff || adv2;
   assign adv1  = v1_ff && take2;
   assign take1 = !v1_ff || adv1;

   assign req.ready = take1 && !ring_clearing;
   assign accept    = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (take1) v1_ff <= accept;
         if (take2) v2_ff <= adv1;
         if (take3) v3_ff <= adv2;
         if (take4) v4_ff <= adv3;
         if (take5) v5_ff <= adv4;
      end
   end

   // write pointer and read address
   logic [AW-1:0] wi_ff;
   logic [AW:0]   diff;
   logic [AW:0]   diff_wrap;
   logic [AW-1:0] ri;

   always_ff @(posedge clock) begin
      if (reset) begin
         wi_ff <= '0;
      end else if (accept) begin
         wi_ff <= (wi_ff == LastAddr) ? '0 : wi_ff + 1'b1;
      end
   end

   always_comb begin
      diff      = {1'b0, wi_ff} - {1'b0, back};
      diff_wrap = diff + DepthX;
      ri        = diff[AW] ? diff_wrap[AW-1:0] : diff[AW-1:0];
   end

   // stage 1: center and side products
   logic signed [SampleWidth-1:0] l1_ff, r1_ff;
   logic [AW-1:0]                 wi1_ff, ri1_ff;
   logic signed [16:0]            sum1;
   logic signed [SampleWidth-1:0] center1;
   logic signed [16:0]            dl1, dr1;
   logic signed [11:0]            gain1;
   logic signed [28:0]            pl_in, pr_in;

   always_ff @(posedge clock) begin
      if (accept) begin
         l1_ff  <= req.left_in;
         r1_ff  <= req.right_in;
         wi1_ff <= wi_ff;
         ri1_ff <= ri;
      end
   end

   always_comb begin
      sum1    = {l1_ff[15], l1_ff} + {r1_ff[15], r1_ff};
      center1 = sum1[16:1];
      dl1     = {l1_ff[15], l1_ff} - {center1[15], center1};
      dr1     = {r1_ff[15], r1_ff} - {center1[15], center1};
      gain1   = {1'b0, width_gain_ff};
      pl_in   = dl1 * gain1;
      pr_in   = dr1 * gain1;
   end

   // stage 2: widened pair, ring write and read
   logic signed [SampleWidth-1:0] c2_ff;
   logic signed [28:0]            pl2_ff, pr2_ff;
   logic [AW-1:0]                 wi2_ff, ri2_ff;
   logic signed [21:0]            wl2, wr2;
   logic signed [22:0]            msum2;
   logic signed [21:0]            mid2;
   logic signed [SampleWidth-1:0] store2;

   always_ff @(posedge clock) begin
      if (adv1) begin
         c2_ff  <= center1;
         pl2_ff <= pl_in;
         pr2_ff <= pr_in;
         wi2_ff <= wi1_ff;
         ri2_ff <= ri1_ff;
      end
   end

   always_comb begin
      wl2   = {{6{c2_ff[15]}}, c2_ff} + {pl2_ff[28], pl2_ff[28:8]};
      wr2   = {{6{c2_ff[15]}}, c2_ff} + {pr2_ff[28], pr2_ff[28:8]};
      msum2 = {wl2[21], wl2} + {wr2[21], wr2};
      mid2  = msum2[22:1];
      if (surround_on) begin
         store2 = sat16({{2{mid2[21]}}, mid2});
      end else begin
         store2 = sat16({{2{wr2[21]}}, wr2});
      end
   end

   logic signed [SampleWidth-1:0] ring_rd_data;

   swde_ring #(.DelayDepth(DelayDepth)) u_ring (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (adv2),
      .wr_addr  (wi2_ff),
      .wr_data  (store2),
      .rd_en    (adv2),
      .rd_addr  (ri2_ff),
      .rd_data  (ring_rd_data),
      .clearing (ring_clearing)
   );

   // stage 3: delayed sample, own write forwarded for zero delay
   logic signed [21:0]            wl3_ff, wr3_ff;
   logic signed [SampleWidth-1:0] st3_ff;
   logic                          fwd3_ff;
   logic signed [SampleWidth-1:0] ds3;
   logic signed [9:0]             sg3;
   logic signed [25:0]            dp_in;

   always_ff @(posedge clock) begin
      if (adv2) begin
         wl3_ff  <= wl2;
         wr3_ff  <= wr2;
         st3_ff  <= store2;
         fwd3_ff <= (ri2_ff == wi2_ff);
      end
   end

   always_comb begin
      ds3   = fwd3_ff ? st3_ff : ring_rd_data;
      sg3   = {1'b0, surround_gain_ff};
      dp_in = ds3 * sg3;
   end

   // stage 4: mix and saturate
   logic signed [21:0]            wl4_ff, wr4_ff;
   logic signed [25:0]            dp4_ff;
   logic signed [SampleWidth-1:0] ds4_ff;
   logic signed [17:0]            d4;
   logic signed [23:0]            lo4, ro4;

   always_ff @(posedge clock) begin
      if (adv3) begin
         wl4_ff <= wl3_ff;
         wr4_ff <= wr3_ff;
         dp4_ff <= dp_in;
         ds4_ff <= ds3;
      end
   end

   always_comb begin
      d4 = dp4_ff[25:8];
      if (surround_on) begin
         lo4 = {{2{wl4_ff[21]}}, wl4_ff} + {{6{d4[17]}}, d4};
         ro4 = {{2{wr4_ff[21]}}, wr4_ff} - {{6{d4[17]}}, d4};
      end else begin
         lo4 = {{2{wl4_ff[21]}}, wl4_ff};
         ro4 = {{8{ds4_ff[15]}}, ds4_ff};
      end
   end

   // stage 5: output register
   logic signed [SampleWidth-1:0] lo5_ff, ro5_ff;

   always_ff @(posedge clock) begin
      if (adv4) begin
         lo5_ff <= sat16(lo4);
         ro5_ff <= sat16(ro4);
      end
   end

   assign rsp.valid     = v5_ff;
   assign rsp.left_out  = lo5_ff;
   assign rsp.right_out = ro5_ff;

endmodule
`default_nettype wire

FILE: rtl/core/swde_delay_mod.sv
`default_nettype none
module swde_delay_mod #(
   parameter int DelayDepth = swde_pkg::DefaultDelayDepth
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [swde_pkg::DelayWidth-1:0]     value,
   output logic [$clog2(DelayDepth)-1:0]            remainder
);
   import swde_pkg::*;

   localparam int AW    = $clog2(DelayDepth);
   localparam int Shift = 28;
   localparam int PW    = DelayWidth + 25;
   localparam int QW    = PW - Shift;
   localparam logic [PW-1:0] Recip  = PW'((2 ** Shift + DelayDepth - 1) / DelayDepth);
   localparam logic [PW-1:0] DepthP = PW'(DelayDepth);

   logic [PW-1:0]         prod;
   logic [QW-1:0]         quot;
   logic [PW-1:0]         back_prod;
   logic [DelayWidth-1:0] rem_in;
   logic [AW-1:0]         rem_ff;

   // quotient by reciprocal multiply, exact over the whole 12-bit range
   always_comb begin
      prod      = PW'(value) * Recip;
      quot      = prod[PW-1:Shift];
      back_prod = PW'(quot) * DepthP;
      rem_in    = value - back_prod[DelayWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else if (start) begin
         rem_ff <= AW'(rem_in);
      end
   end

   assign remainder = rem_ff;

endmodule
`default_nettype wire

FILE: rtl/core/swde_ring.sv
`default_nettype none
module swde_ring #(
   parameter int DelayDepth = swde_pkg::DefaultDelayDepth
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  wr_en,
   input  wire logic [$clog2(DelayDepth)-1:0]         wr_addr,
   input  wire logic signed [swde_pkg::SampleWidth-1:0] wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [$clog2(DelayDepth)-1:0]         rd_addr,
   output logic signed [swde_pkg::SampleWidth-1:0]    rd_data,
   output logic                                       clearing
);
   import swde_pkg::*;

   localparam int AW = $clog2(DelayDepth);
   localparam logic [AW-1:0] LastAddr = AW'(DelayDepth - 1);

   logic signed [SampleWidth-1:0] mem [DelayDepth];
   logic signed [SampleWidth-1:0] rd_data_ff;
   logic                          clear_ff;
   logic [AW-1:0]                 clear_addr_ff;
   logic                          mem_we;
   logic [AW-1:0]                 mem_addr;
   logic signed [SampleWidth-1:0] mem_data;

   // zero sweep after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_ff) begin
         clear_addr_ff <= clear_addr_ff + 1'b1;
         if (clear_addr_ff == LastAddr) begin
            clear_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      if (clear_ff) begin
         mem_we   = 1'b1;
         mem_addr = clear_addr_ff;
         mem_data = '0;
      end else begin
         mem_we   = wr_en;
         mem_addr = wr_addr;
         mem_data = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clear_ff;

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import swde_pkg::*;

   localparam int RingDepth   = DefaultDelayDepth;
   localparam int CycleLimit  = 400000;
   localparam int RandomSets  = 14;
   localparam int FramesPerSet = 100;

   typedef struct packed {
      logic signed [SampleWidth-1:0] left;
      logic signed [SampleWidth-1:0] right;
   } stereo_frame_type;

   class width_delay_checker;
      logic [WidthGainWidth-1:0]    width_gain;
      logic [SurroundGainWidth-1:0] surround_gain;
      logic [DelayWidth-1:0]        delay_len;
      logic signed [SampleWidth-1:0] ring [RingDepth];
      logic [DelayWidth-1:0]        write_pos;
      stereo_frame_type             pending_frames [$];
      int                           mismatches;
      int                           frames_checked;
      int                           surround_frames;

      function new();
         width_gain      = WidthGainReset;
         surround_gain   = SurroundGainReset;
         delay_len       = '0;
         write_pos       = '0;
         mismatches      = 0;
         frames_checked  = 0;
         surround_frames = 0;
         foreach (ring[i]) ring[i] = '0;
      endfunction

      function void set_reg(csr_index_type idx, logic [CsrDataWidth-1:0] value);
         case (idx)
            CSR_WIDTH_GAIN:    width_gain    = value[WidthGainWidth-1:0];
            CSR_SURROUND_GAIN: surround_gain = value[SurroundGainWidth-1:0];
            CSR_DELAY_LEN:     delay_len     = value[DelayWidth-1:0];
            default: ;
         endcase
      endfunction

      function logic signed [SampleWidth-1:0] clip16(longint x);
         if (x > 32767) return 16'sh7fff;
         if (x < -32768) return 16'sh8000;
         return x[SampleWidth-1:0];
      endfunction

      // widen about the mid value, then run the delay ring
      function stereo_frame_type widen_and_delay(logic signed [SampleWidth-1:0] l_in,
                                                 logic signed [SampleWidth-1:0] r_in);
         longint l, r, center, wl, wr, wg, sg, held, shift, lo, ro;
         logic [DelayWidth-1:0] read_pos;
         stereo_frame_type res;
         l = l_in;
         r = r_in;
         wg = width_gain;
         sg = surround_gain;
         center = (l + r) >>> 1;
         wl = center + (((l - center) * wg) >>> 8);
         wr = center + (((r - center) * wg) >>> 8);
         read_pos = write_pos - delay_len;
         if (surround_gain != 0) begin
            ring[write_pos] = clip16((wl + wr) >>> 1);
            held = ring[read_pos];
            shift = (held * sg) >>> 8;
            lo = wl + shift;
            ro = wr - shift;
         end else begin
            ring[write_pos] = clip16(wr);
            lo = wl;
            ro = ring[read_pos];
         end
         write_pos = write_pos + 1'b1;
         res.left  = clip16(lo);
         res.right = clip16(ro);
         return res;
      endfunction

      function void note_request(logic signed [SampleWidth-1:0] l,
                                 logic signed [SampleWidth-1:0] r);
         if (surround_gain != 0) surround_frames++;
         pending_frames.push_back(widen_and_delay(l, r));
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_result(logic signed [SampleWidth-1:0] l, logic signed [SampleWidth-1:0] r);
         stereo_frame_type want;
         if (pending_frames.size() == 0) begin
            report($sformatf("unexpected frame left %0d right %0d", l, r));
            return;
         end
         want = pending_frames.pop_front();
         frames_checked++;
         if (l !== want.left)
            report($sformatf("left_out %0d, expected %0d", l, want.left));
         if (r !== want.right)
            report($sformatf("right_out %0d, expected %0d", r, want.right));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;
   bit   calm = 1'b0;
   int   cycles = 0;
   int   settings_used = 0;
   width_delay_checker sb;

   swde_req_if req_bus ();
   swde_rsp_if rsp_bus ();

   stereo_width_delay_enhancer u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && sb != null) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_request(req_bus.left_in, req_bus.right_in);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result(rsp_bus.left_out, rsp_bus.right_out);
      end
   end

   // result side back-pressure
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   function automatic logic signed [SampleWidth-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'($urandom_range(0, 64) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_frame(logic signed [SampleWidth-1:0] l,
                             logic signed [SampleWidth-1:0] r);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.left_in  <= l;
      req_bus.right_in <= r;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_frames.size() != 0) @(posedge clock);
   endtask

   task automatic write_csrs(int unsigned w, int unsigned s, int unsigned d);
      csr_we    <= 1'b1;
      csr_index <= CSR_WIDTH_GAIN;
      csr_wdata <= CsrDataWidth'(w);
      @(posedge clock);
      sb.set_reg(CSR_WIDTH_GAIN, CsrDataWidth'(w));
      csr_index <= CSR_SURROUND_GAIN;
      csr_wdata <= CsrDataWidth'(s);
      @(posedge clock);
      sb.set_reg(CSR_SURROUND_GAIN, CsrDataWidth'(s));
      csr_index <= CSR_DELAY_LEN;
      csr_wdata <= CsrDataWidth'(d);
      @(posedge clock);
      sb.set_reg(CSR_DELAY_LEN, CsrDataWidth'(d));
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic directed_set();
      logic signed [SampleWidth-1:0] extremes [8];
      extremes = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff,
                   16'sh0001, 16'sh8001, 16'sh4000, 16'shbfff};
      for (int i = 0; i < 8; i++)
         send_frame(extremes[i], extremes[(i * 3 + 1) % 8]);
      drain();
   endtask

   initial begin
      int unsigned w, s, d;
      sb = new();
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_index        <= CSR_WIDTH_GAIN;
      csr_wdata        <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.left_in  <= '0;
      req_bus.right_in <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, then the gain and delay extremes
      settings_used = 1;
      directed_set();
      write_csrs(2047, 511, 0);
      directed_set();
      write_csrs(0, 256, 4095);
      directed_set();

      for (int k = 0; k < RandomSets; k++) begin
         case (k)
            0: begin w = 0;    s = 0;   d = 1;    end
            1: begin w = 2047; s = 511; d = 4095; end
            2: begin w = 1024; s = 256; d = 0;    end
            3: begin w = 256;  s = 1;   d = 2;    end
            default: begin
               w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                               : $urandom_range(0, 1024);
               s = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 511);
               d = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 40)
                                               : $urandom_range(0, 4095);
            end
         endcase
         if (k >= RandomSets - 2) calm = 1'b1;
         write_csrs(w, s, d);
         for (int n = 0; n < FramesPerSet; n++)
            send_frame(pick_sample(), pick_sample());
         drain();
      end

      repeat (20) @(posedge clock);
      $display("checked %0d frames under %0d register settings, %0d in surround mode",
               sb.frames_checked, settings_used, sb.surround_frames);
      $display("%0d mismatches", sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_frames.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
